// ===== src/tapp_pkg.sv =====
// tapp_pkg: types, constants and helpers for the track axis plane projection pipeline.
// No dependencies; imported by track_axis_plane_projection.

package tapp_pkg;

   // pipeline layout
   localparam int StgIn      = 0;   // operand capture, direction, time x speed
   localparam int StgOffRem  = 1;   // offset: fold quotient remainder
   localparam int StgOffMul  = 2;   // offset: reciprocal multiply
   localparam int StgOff     = 3;   // offset: final sum
   localparam int StgWin     = 4;   // window test, numerator
   localparam int StgMul     = 5;   // numerator x direction
   localparam int StgDivPrep = 6;   // rounding bias, magnitude
   localparam int StgDiv0    = 7;   // first divider stage
   localparam int DivStages  = 11;
   localparam int DivSteps   = 4;
   localparam int StgQuot    = StgDiv0 + DivStages;   // signed quotient, crossing
   localparam int StgErr     = StgQuot + 1;           // error vector, saturation
   localparam int StgSq      = StgErr + 1;            // partial squares
   localparam int StgSqCmb   = StgSq + 1;             // squares, 64 bit
   localparam int StgSum     = StgSqCmb + 1;          // sum of squares
   localparam int StgSqrt0   = StgSum + 1;            // first root stage
   localparam int SqrtStages = 8;
   localparam int SqrtSteps  = 4;
   localparam int StgOut     = StgSqrt0 + SqrtStages; // rounding, result
   localparam int NumStages  = StgOut + 1;

   // status codes
   localparam logic [1:0] StatusProj     = 2'd0;
   localparam logic [1:0] StatusParallel = 2'd1;
   localparam logic [1:0] StatusWindow   = 2'd2;

   // panel codes
   localparam logic [1:0] PanelBottom = 2'd0;
   localparam logic [1:0] PanelTop    = 2'd3;

   // register map
   localparam int AddrW = 4;
   localparam int DataW = 32;
   localparam logic [1:0] RegDrift = 2'd0;
   localparam logic [1:0] RegWinUp = 2'd1;
   localparam logic [1:0] RegWinLo = 2'd2;

   localparam logic [15:0]        DriftReset = 16'd7300;
   localparam logic signed [19:0] WinUpReset = 20'sd16640;
   localparam logic signed [19:0] WinLoReset = -20'sd640;

   // offset = floor((t*v + 512000) / 1024000): shift by 13, then divide by 125
   // as x = xh*2^18 + xl = xh*(2097*125 + 19) + xl
   localparam logic signed [48:0] OffHalf  = 49'sd512000;
   localparam logic signed [22:0] RemMul   = 23'sd19;
   localparam logic signed [29:0] XhMul    = 30'sd2097;
   localparam logic signed [23:0] RemBias  = 24'sd4096000;   // 125 * 2^15
   localparam logic [23:0]        RecipMul = 24'd8589935;    // ceil(2^30 / 125)
   localparam logic signed [29:0] QuotBias = 30'sd32768;

   localparam logic [20:0] DistMax = 21'h1FFFFF;

   typedef logic signed [19:0] coord_type;

   typedef struct {
      coord_type               hit [3];
      coord_type               mid [3];
      coord_type               ax;
      coord_type               bx;
      logic                    ksel;      // normal axis is y
      logic signed [20:0]      dir [3];
      logic signed [20:0]      den;
      logic                    par;
      logic signed [48:0]      prod;
      logic signed [17:0]      xh;
      logic signed [22:0]      rsm;
      coord_type               maxx;
      coord_type               minx;
      logic [16:0]             qr;
      logic signed [29:0]      xq;
      logic signed [29:0]      off;
      logic [1:0]              status;
      logic signed [30:0]      cx;
      logic signed [32:0]      nums;
      logic [20:0]             dmag;
      logic signed [53:0]      qv [3];
      logic                    neg [3];
      logic [21:0]             drem [3];
      logic [43:0]             dlo [3];
      logic signed [47:0]      pt [3];
      logic [41:0]             ae [3];
      coord_type               crs [3];
      logic                    clipc;
      logic [41:0]             sqh [3];
      logic [41:0]             sqm [3];
      logic [41:0]             sql [3];
      logic [63:0]             sq [3];
      logic [63:0]             ssrc;
      logic [31:0]             root;
      logic [33:0]             srem;
      logic [20:0]             dlen;
      logic                    clip;
   } item_type;

   // saturate to 20 bit signed, clip flag on top
   function automatic logic [20:0] sat20(input logic signed [48:0] v);
      if (v > 49'sd524287) begin
         return {1'b1, 20'h7FFFF};
      end else if (v < -49'sd524288) begin
         return {1'b1, 20'h80000};
      end else begin
         return {1'b0, v[19:0]};
      end
   endfunction

endpackage

// ===== src/track_axis_plane_projection.sv =====
// Track axis to detector panel projection, fully pipelined datapath and CSR block.
// Depends on tapp_pkg (types, stage map, constants).
//
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | axis endpoints, centroid, hit, panel, time
//  rsp     | out | rsp_valid/rsp_ready  | status, distance, crossing, clipped
//  csr     | in  | APB psel/penable     | drift_speed, window_upper, window_lower
//
// One beat per cycle sustained while rsp_ready holds high, over 32 stages. The depth is
// set by the restoring divider (44 quotient bits, 4 per stage, 11 stages) and
// the root extractor (32 root bits, 4 per stage, 8 stages). Each stage loads
// when it is empty or the next one moves, so stalls at rsp fill bubbles before
// req_ready drops. Reset clears all stage valids and loads the register defaults.

module track_axis_plane_projection (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [19:0]          req_end_a_x,
   input  logic signed [19:0]          req_end_a_y,
   input  logic signed [19:0]          req_end_a_z,
   input  logic signed [19:0]          req_end_b_x,
   input  logic signed [19:0]          req_mid_x,
   input  logic signed [19:0]          req_mid_y,
   input  logic signed [19:0]          req_mid_z,
   input  logic signed [19:0]          req_hit_x,
   input  logic signed [19:0]          req_hit_y,
   input  logic signed [19:0]          req_hit_z,
   input  logic [1:0]                  req_panel_id,
   input  logic signed [31:0]          req_hit_time,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [20:0]                 rsp_distance,
   output logic signed [19:0]          rsp_cross_x,
   output logic signed [19:0]          rsp_cross_y,
   output logic signed [19:0]          rsp_cross_z,
   output logic                        rsp_clipped,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [tapp_pkg::AddrW-1:0]  csr_paddr,
   input  logic [tapp_pkg::DataW-1:0]  csr_pwdata,
   output logic [tapp_pkg::DataW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import tapp_pkg::*;

   logic [15:0]        drift_ff;
   logic signed [19:0] wupper_ff;
   logic signed [19:0] wlower_ff;

   logic [NumStages-1:0] v_ff;
   logic [NumStages-1:0] v_in;
   logic [NumStages:0]   adv;
   item_type             st_ff [NumStages];
   item_type             st_in [NumStages];

   logic csr_wr;

   // ---------------- CSR ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         drift_ff  <= DriftReset;
         wupper_ff <= WinUpReset;
         wlower_ff <= WinLoReset;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            RegDrift: drift_ff  <= csr_pwdata[15:0];
            RegWinUp: wupper_ff <= $signed(csr_pwdata[19:0]);
            RegWinLo: wlower_ff <= $signed(csr_pwdata[19:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         RegDrift: csr_prdata = {16'd0, drift_ff};
         RegWinUp: csr_prdata = 32'(wupper_ff);
         RegWinLo: csr_prdata = 32'(wlower_ff);
         default:  csr_prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   always_comb begin
      adv[NumStages] = rsp_ready;
      for (int s = NumStages - 1; s >= 0; s--) begin
         adv[s] = !v_ff[s] || adv[s+1];
      end
      v_in[0] = req_valid;
      for (int s = 1; s < NumStages; s++) begin
         v_in[s] = v_ff[s-1];
      end
   end

   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < NumStages; s++) begin
            if (adv[s]) v_ff[s] <= v_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NumStages; s++) begin
         if (adv[s]) st_ff[s] <= st_in[s];
      end
   end

   // ---------------- datapath ----------------
   always_comb begin
      logic signed [20:0] dx, dy, dz, dk;
      logic               ks;
      logic signed [48:0] nv49;
      logic signed [23:0] rb24;
      logic [46:0]        mp;
      logic signed [30:0] vmax, vmin, ck;
      logic               outw;
      logic signed [31:0] num;
      logic signed [21:0] dd;
      logic signed [55:0] nv56;
      logic [55:0]        mag;
      logic [21:0]        d2;
      logic [22:0]        t23;
      logic [21:0]        wr;
      logic [43:0]        wl;
      logic [44:0]        qsum;
      logic signed [45:0] qs;
      logic signed [30:0] ci;
      logic signed [48:0] ev, ea, cv;
      logic [20:0]        sr;
      logic               anyclip;
      logic [20:0]        hi, lo;
      logic [63:0]        sum;
      logic [63:0]        src;
      logic [31:0]        rt;
      logic [33:0]        rm;
      logic [35:0]        t36, trial;
      logic [32:0]        rnd;

      // stage 0: capture, direction, time x speed
      st_in[StgIn] = '{default: '0};
      st_in[StgIn].hit[0] = req_hit_x;
      st_in[StgIn].hit[1] = req_hit_y;
      st_in[StgIn].hit[2] = req_hit_z;
      st_in[StgIn].mid[0] = req_mid_x;
      st_in[StgIn].mid[1] = req_mid_y;
      st_in[StgIn].mid[2] = req_mid_z;
      st_in[StgIn].ax = req_end_a_x;
      st_in[StgIn].bx = req_end_b_x;
      ks = (req_panel_id == PanelBottom) || (req_panel_id == PanelTop);
      dx = 21'(req_end_a_x) - 21'(req_mid_x);
      dy = 21'(req_end_a_y) - 21'(req_mid_y);
      dz = 21'(req_end_a_z) - 21'(req_mid_z);
      dk = ks ? dy : dx;
      st_in[StgIn].ksel   = ks;
      st_in[StgIn].dir[0] = dx;
      st_in[StgIn].dir[1] = dy;
      st_in[StgIn].dir[2] = dz;
      st_in[StgIn].den    = dk;
      st_in[StgIn].par    = (dk == 21'sd0);
      st_in[StgIn].prod   = req_hit_time * $signed({1'b0, drift_ff});

      // stage 1: round bias, shift by 13, split for the divide by 125
      st_in[StgOffRem] = st_ff[StgOffRem-1];
      nv49 = st_ff[StgOffRem-1].prod + OffHalf;
      st_in[StgOffRem].xh  = $signed(nv49[48:31]);
      st_in[StgOffRem].rsm = 23'($signed(nv49[48:31])) * RemMul
                             + $signed({5'd0, nv49[30:13]});
      st_in[StgOffRem].maxx = st_ff[StgOffRem-1].ax;
      if (st_ff[StgOffRem-1].bx > st_in[StgOffRem].maxx) begin
         st_in[StgOffRem].maxx = st_ff[StgOffRem-1].bx;
      end
      if (st_in[StgOffRem].maxx < 20'sd0) st_in[StgOffRem].maxx = 20'sd0;
      st_in[StgOffRem].minx = (st_ff[StgOffRem-1].ax < st_ff[StgOffRem-1].bx)
                              ? st_ff[StgOffRem-1].ax : st_ff[StgOffRem-1].bx;

      // stage 2: remainder / 125 by reciprocal, whole part x 2097
      st_in[StgOffMul] = st_ff[StgOffMul-1];
      rb24 = 24'(st_ff[StgOffMul-1].rsm) + RemBias;
      mp   = 47'(rb24[22:0]) * 47'(RecipMul);
      st_in[StgOffMul].qr = mp[46:30];
      st_in[StgOffMul].xq = 30'(st_ff[StgOffMul-1].xh) * XhMul;

      // stage 3: offset
      st_in[StgOff] = st_ff[StgOff-1];
      st_in[StgOff].off = st_ff[StgOff-1].xq + $signed({13'd0, st_ff[StgOff-1].qr})
                          - QuotBias;

      // stage 4: window, corrected centroid, numerator sign-folded by den
      st_in[StgWin] = st_ff[StgWin-1];
      vmax = 31'(st_ff[StgWin-1].maxx) - 31'(st_ff[StgWin-1].off);
      vmin = 31'(st_ff[StgWin-1].minx) - 31'(st_ff[StgWin-1].off);
      outw = (vmax >= 31'(wupper_ff)) || (vmax < 31'(wlower_ff)) ||
             (vmin >= 31'(wupper_ff)) || (vmin < 31'(wlower_ff));
      priority if (st_ff[StgWin-1].par) st_in[StgWin].status = StatusParallel;
      else if (outw)                   st_in[StgWin].status = StatusWindow;
      else                             st_in[StgWin].status = StatusProj;
      st_in[StgWin].cx = 31'(st_ff[StgWin-1].mid[0]) - 31'(st_ff[StgWin-1].off);
      ck  = st_ff[StgWin-1].ksel ? 31'(st_ff[StgWin-1].mid[1]) : st_in[StgWin].cx;
      num = (st_ff[StgWin-1].ksel ? 32'(st_ff[StgWin-1].hit[1])
                                  : 32'(st_ff[StgWin-1].hit[0])) - 32'(ck);
      st_in[StgWin].nums = st_ff[StgWin-1].den[20] ? -33'(num) : 33'(num);
      dd = st_ff[StgWin-1].den[20] ? -22'(st_ff[StgWin-1].den)
                                   : 22'(st_ff[StgWin-1].den);
      st_in[StgWin].dmag = dd[20:0];

      // stage 5: products
      st_in[StgMul] = st_ff[StgMul-1];
      for (int i = 0; i < 3; i++) begin
         st_in[StgMul].qv[i] = 54'(st_ff[StgMul-1].nums) * 54'(st_ff[StgMul-1].dir[i]);
      end

      // stage 6: N = 2q + |den|, divide by 2|den| with floor
      st_in[StgDivPrep] = st_ff[StgDivPrep-1];
      for (int i = 0; i < 3; i++) begin
         nv56 = (56'(st_ff[StgDivPrep-1].qv[i]) <<< 1)
                + $signed({35'd0, st_ff[StgDivPrep-1].dmag});
         mag  = nv56[55] ? 56'(-nv56) : 56'(nv56);
         st_in[StgDivPrep].neg[i]  = nv56[55];
         // a pair that passes the window keeps |N| below 2^43
         st_in[StgDivPrep].drem[i] = '0;
         st_in[StgDivPrep].dlo[i]  = mag[43:0];
      end

      // divider: dividend bits shift out of dlo, quotient bits shift in
      for (int s = StgDiv0; s < StgDiv0 + DivStages; s++) begin
         st_in[s] = st_ff[s-1];
         d2 = {st_ff[s-1].dmag, 1'b0};
         for (int i = 0; i < 3; i++) begin
            wr = st_ff[s-1].drem[i];
            wl = st_ff[s-1].dlo[i];
            for (int j = 0; j < DivSteps; j++) begin
               t23 = {wr, wl[43]};
               wl  = {wl[42:0], 1'b0};
               if (t23 >= {1'b0, d2}) begin
                  wr    = 22'(t23 - {1'b0, d2});
                  wl[0] = 1'b1;
               end else begin
                  wr = t23[21:0];
               end
            end
            st_in[s].drem[i] = wr;
            st_in[s].dlo[i]  = wl;
         end
      end

      // signed floored quotient, crossing before offset restore
      st_in[StgQuot] = st_ff[StgQuot-1];
      for (int i = 0; i < 3; i++) begin
         qsum = 45'(st_ff[StgQuot-1].dlo[i])
                + 45'(st_ff[StgQuot-1].neg[i] && (st_ff[StgQuot-1].drem[i] != 22'd0));
         qs   = st_ff[StgQuot-1].neg[i] ? -$signed({1'b0, qsum}) : $signed({1'b0, qsum});
         ci   = (i == 0) ? st_ff[StgQuot-1].cx : 31'(st_ff[StgQuot-1].mid[i]);
         st_in[StgQuot].pt[i] = 48'(ci) + 48'(qs);
      end

      // error vector and saturated crossing
      st_in[StgErr] = st_ff[StgErr-1];
      anyclip = 1'b0;
      for (int i = 0; i < 3; i++) begin
         ev = 49'(st_ff[StgErr-1].hit[i]) - 49'(st_ff[StgErr-1].pt[i]);
         ea = ev[48] ? -ev : ev;
         st_in[StgErr].ae[i] = ea[41:0];
         cv = (i == 0) ? 49'(st_ff[StgErr-1].pt[i]) + 49'(st_ff[StgErr-1].off)
                       : 49'(st_ff[StgErr-1].pt[i]);
         sr = sat20(cv);
         anyclip = anyclip || sr[20];
         st_in[StgErr].crs[i] = $signed(sr[19:0]);
      end
      st_in[StgErr].clipc = anyclip;

      // partial squares on 21-bit halves
      st_in[StgSq] = st_ff[StgSq-1];
      for (int i = 0; i < 3; i++) begin
         hi = st_ff[StgSq-1].ae[i][41:21];
         lo = st_ff[StgSq-1].ae[i][20:0];
         st_in[StgSq].sqh[i] = 42'(hi) * 42'(hi);
         st_in[StgSq].sqm[i] = 42'(hi) * 42'(lo);
         st_in[StgSq].sql[i] = 42'(lo) * 42'(lo);
      end

      // squares wrap at 64 bits
      st_in[StgSqCmb] = st_ff[StgSqCmb-1];
      for (int i = 0; i < 3; i++) begin
         st_in[StgSqCmb].sq[i] = (64'(st_ff[StgSqCmb-1].sqh[i]) << 42)
                                 + (64'(st_ff[StgSqCmb-1].sqm[i]) << 22)
                                 + 64'(st_ff[StgSqCmb-1].sql[i]);
      end

      // sum of squares, also 64-bit wrap
      st_in[StgSum] = st_ff[StgSum-1];
      sum = st_ff[StgSum-1].sq[0] + st_ff[StgSum-1].sq[1] + st_ff[StgSum-1].sq[2];
      st_in[StgSum].ssrc = sum;
      st_in[StgSum].root = '0;
      st_in[StgSum].srem = '0;

      // root extraction, two radicand bits per step
      for (int s = StgSqrt0; s < StgSqrt0 + SqrtStages; s++) begin
         st_in[s] = st_ff[s-1];
         src = st_ff[s-1].ssrc;
         rt  = st_ff[s-1].root;
         rm  = st_ff[s-1].srem;
         for (int j = 0; j < SqrtSteps; j++) begin
            t36   = {rm, src[63:62]};
            src   = {src[61:0], 2'b00};
            trial = {2'b00, rt, 2'b01};
            if (t36 >= trial) begin
               rm = 34'(t36 - trial);
               rt = {rt[30:0], 1'b1};
            end else begin
               rm = t36[33:0];
               rt = {rt[30:0], 1'b0};
            end
         end
         st_in[s].ssrc = src;
         st_in[s].root = rt;
         st_in[s].srem = rm;
      end

      // round to nearest, saturate, blank rejected pairs
      st_in[StgOut] = st_ff[StgOut-1];
      rnd = 33'(st_ff[StgOut-1].root)
            + 33'(st_ff[StgOut-1].srem > 34'(st_ff[StgOut-1].root));
      if (rnd > 33'(DistMax)) begin
         st_in[StgOut].dlen = DistMax;
         st_in[StgOut].clip = 1'b1;
      end else begin
         st_in[StgOut].dlen = rnd[20:0];
         st_in[StgOut].clip = st_ff[StgOut-1].clipc;
      end
      if (st_ff[StgOut-1].status != StatusProj) begin
         st_in[StgOut].dlen = '0;
         st_in[StgOut].clip = 1'b0;
         for (int i = 0; i < 3; i++) begin
            st_in[StgOut].crs[i] = '0;
         end
      end
   end

   assign rsp_valid    = v_ff[StgOut];
   assign rsp_status   = st_ff[StgOut].status;
   assign rsp_distance = st_ff[StgOut].dlen;
   assign rsp_cross_x  = st_ff[StgOut].crs[0];
   assign rsp_cross_y  = st_ff[StgOut].crs[1];
   assign rsp_cross_z  = st_ff[StgOut].crs[2];
   assign rsp_clipped  = st_ff[StgOut].clip;

   // ---------------- assertions ----------------
   a_ready_on_bubble: assert property (@(posedge clock) disable iff (reset)
      !v_ff[StgOut] |-> req_ready)
      else $error("req_ready low with an empty output stage");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff[StgQuot-1] && (st_ff[StgQuot-1].status == StatusProj)
      |-> st_ff[StgQuot-1].drem[0] < {st_ff[StgQuot-1].dmag, 1'b0})
      else $error("divider remainder not below divisor");

   a_sqrt_rem_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff[StgOut-1] |-> st_ff[StgOut-1].srem <= {1'b0, st_ff[StgOut-1].root, 1'b0})
      else $error("root remainder above twice the root");

   a_reject_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != StatusProj)
      |-> (rsp_distance == '0) && (rsp_cross_x == '0) && (rsp_cross_y == '0) &&
          (rsp_cross_z == '0) && !rsp_clipped)
      else $error("rejected beat carries nonzero result fields");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for track_axis_plane_projection: a predicting scoreboard, tasks that drive
// the req and csr ports, and a process that drives rsp. Depends on tapp_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
   import tapp_pkg::*;

   typedef struct {
      coord_type         ax, ay, az, bx, mx, my, mz, hx, hy, hz;
      logic [1:0]        panel;
      logic signed [31:0] t;
   } pair_type;

   typedef struct {
      logic [1:0]  status;
      logic [20:0] dlen;
      coord_type   cx, cy, cz;
      logic        clip;
   } proj_type;

   class proj_scoreboard;
      proj_type    pending[$];
      int          errors = 0;
      logic [15:0] drift = DriftReset;
      longint      win_up = WinUpReset;
      longint      win_lo = WinLoReset;

      function longint fdiv(longint n, longint d);
         if (n >= 0) return n / d;
         return -((-n + d - 1) / d);
      endfunction

      function longint offset(logic signed [31:0] t);
         return fdiv(longint'(t) * longint'({1'b0, drift}) + 512000, 1024000);
      endfunction

      function longint unsigned root_round(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         if (v > r) r = r + 1;
         return r;
      endfunction

      function coord_type sat(longint v, ref bit clip);
         if (v > 524287) begin
            clip = 1;
            return 20'sh7FFFF;
         end
         if (v < -524288) begin
            clip = 1;
            return 20'sh80000;
         end
         return coord_type'(v);
      endfunction

      function proj_type project(pair_type x);
         proj_type r;
         longint a[3], m[3], h[3], d[3], c[3], p[3];
         longint off, maxx, minx, num, den, q, e;
         longint unsigned sum, ue, dlen;
         int k;
         bit clip;
         r = '{StatusProj, 0, 0, 0, 0, 0};
         clip = 0;
         sum = 0;
         a = '{x.ax, x.ay, x.az};
         m = '{x.mx, x.my, x.mz};
         h = '{x.hx, x.hy, x.hz};
         k = (x.panel == PanelBottom || x.panel == PanelTop) ? 1 : 0;
         for (int i = 0; i < 3; i++) d[i] = a[i] - m[i];
         if (d[k] == 0) begin
            r.status = StatusParallel;
            return r;
         end
         off = offset(x.t);
         maxx = 0;
         if (a[0] > maxx) maxx = a[0];
         if (longint'(x.bx) > maxx) maxx = x.bx;
         minx = (a[0] < longint'(x.bx)) ? a[0] : longint'(x.bx);
         if (maxx - off >= win_up || maxx - off < win_lo ||
             minx - off >= win_up || minx - off < win_lo) begin
            r.status = StatusWindow;
            return r;
         end
         c = '{m[0] - off, m[1], m[2]};
         num = h[k] - c[k];
         den = d[k];
         for (int i = 0; i < 3; i++) begin
            q = num * d[i];
            // round half toward +inf for either sign of the divisor
            if (den < 0) p[i] = c[i] + fdiv(-2 * q - den, -2 * den);
            else p[i] = c[i] + fdiv(2 * q + den, 2 * den);
         end
         for (int i = 0; i < 3; i++) begin
            e = h[i] - p[i];
            ue = (e < 0) ? -e : e;
            sum = sum + ue * ue;
         end
         dlen = root_round(sum);
         if (dlen > 2097151) begin
            dlen = 2097151;
            clip = 1;
         end
         r.dlen = dlen[20:0];
         r.cx = sat(p[0] + off, clip);
         r.cy = sat(p[1], clip);
         r.cz = sat(p[2], clip);
         r.clip = clip;
         return r;
      endfunction

      function void note_pair(pair_type x);
         pending = {pending, project(x)};
      endfunction

      function void check_result(proj_type got);
         proj_type want;
         if (pending.size() == 0) begin
            $error("result beat with nothing pending");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.dlen !== want.dlen) begin
            $error("distance: expected %0d, actual %0d", want.dlen, got.dlen);
            errors++;
         end
         if (got.cx !== want.cx) begin
            $error("cross_x: expected %0d, actual %0d", want.cx, got.cx);
            errors++;
         end
         if (got.cy !== want.cy) begin
            $error("cross_y: expected %0d, actual %0d", want.cy, got.cy);
            errors++;
         end
         if (got.cz !== want.cz) begin
            $error("cross_z: expected %0d, actual %0d", want.cz, got.cz);
            errors++;
         end
         if (got.clip !== want.clip) begin
            $error("clipped: expected %0d, actual %0d", want.clip, got.clip);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   pair_type req;
   logic [1:0] rsp_status;
   logic [20:0] rsp_distance;
   coord_type rsp_cross_x, rsp_cross_y, rsp_cross_z;
   logic rsp_clipped;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [AddrW-1:0] csr_paddr;
   logic [DataW-1:0] csr_pwdata, csr_prdata;

   proj_scoreboard sb = new();
   int results_seen = 0;

   track_axis_plane_projection u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_end_a_x(req.ax), .req_end_a_y(req.ay), .req_end_a_z(req.az),
      .req_end_b_x(req.bx), .req_mid_x(req.mx), .req_mid_y(req.my),
      .req_mid_z(req.mz), .req_hit_x(req.hx), .req_hit_y(req.hy),
      .req_hit_z(req.hz), .req_panel_id(req.panel), .req_hit_time(req.t),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_distance(rsp_distance),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y),
      .rsp_cross_z(rsp_cross_z), .rsp_clipped(rsp_clipped),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= AddrW'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_window(logic [15:0] drift, coord_type up, coord_type lo);
      csr_write(RegDrift, {16'd0, drift});
      csr_write(RegWinUp, 32'(signed'(up)));
      csr_write(RegWinLo, 32'(signed'(lo)));
      sb.drift = drift;
      sb.win_up = up;
      sb.win_lo = lo;
   endtask

   task automatic send_pair(pair_type x);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req <= x;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_pair(x);
   endtask

   // well-formed pairs keep both corrected endpoints inside the window
   function automatic pair_type make_pair(bit shaped);
      pair_type x;
      longint off, span;
      x.ax = coord_type'($urandom); x.ay = coord_type'($urandom);
      x.az = coord_type'($urandom); x.bx = coord_type'($urandom);
      x.mx = coord_type'($urandom); x.my = coord_type'($urandom);
      x.mz = coord_type'($urandom);
      x.hx = coord_type'($urandom); x.hy = coord_type'($urandom);
      x.hz = coord_type'($urandom);
      x.panel = 2'($urandom); x.t = $urandom;
      if (!shaped) return x;
      x.t = $urandom_range(0, 40000) - 20000;
      off = sb.offset(x.t);
      span = sb.win_up - sb.win_lo;
      if (span > 0) begin
         if (span > 20000) span = 20000;
         x.ax = coord_type'(sb.win_lo + off + $urandom % span);
         x.bx = coord_type'(sb.win_lo + off + $urandom % span);
      end
      x.ay = coord_type'($urandom_range(0, 8000) - 4000);
      x.az = coord_type'($urandom_range(0, 8000) - 4000);
      x.mx = x.ax + coord_type'($urandom_range(0, 4000) - 2000);
      x.my = coord_type'($urandom_range(0, 8000) - 4000);
      x.mz = coord_type'($urandom_range(0, 8000) - 4000);
      x.hx = coord_type'($urandom_range(0, 40000) - 20000);
      x.hy = coord_type'($urandom_range(0, 40000) - 20000);
      x.hz = coord_type'($urandom_range(0, 40000) - 20000);
      return x;
   endfunction

   task automatic directed_pairs();
      pair_type x;
      for (int p = 0; p < 4; p++) begin
         x = '{100, 200, 300, 400, 50, -300, 120, 900, 2000, -700, p[1:0], 1400};
         send_pair(x);
      end
      // parallel to the panel: no y component, then no x component
      send_pair('{100, 50, 9, 200, 10, 50, 0, 0, 0, 0, PanelBottom, 0});
      send_pair('{100, 50, 9, 200, 100, 7, 0, 0, 0, 0, 2'd1, 0});
      // zero-length axis
      send_pair('{300, 300, 300, 300, 300, 300, 300, 5, 5, 5, PanelTop, 0});
      // out of window on either side
      send_pair('{20000, 10, 0, 100, 0, 0, 0, 0, 0, 0, PanelBottom, 0});
      send_pair('{-5000, 10, 0, 100, 0, 0, 0, 0, 0, 0, PanelBottom, 0});
      send_pair('{100, 10, 0, 100, 0, 0, 0, 0, 0, 0, PanelBottom, 32'sh7FFFFFFF});
      send_pair('{100, 10, 0, 100, 0, 0, 0, 0, 0, 0, PanelBottom, 32'sh80000000});
      // field extremes
      send_pair('{20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh80000, 20'sh80000,
                  20'sh80000, 20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 2'd3, 32'sh7FFFFFFF});
      send_pair('{20'sh80000, 20'sh80000, 20'sh80000, 20'sh80000, 20'sh7FFFF, 20'sh7FFFF,
                  20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 20'sh80000, 2'd1, 32'sh80000000});
      send_pair('{0, 1, 0, 0, 0, 0, 0, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, PanelBottom, 0});
      send_pair('{1, 0, 1, 0, 0, 0, 0, 20'sh80000, 20'sh80000, 20'sh80000, 2'd2, 0});
      send_pair('{16000, 1, 20'sh7FFFF, 0, 0, 0, 20'sh80000, 20'sh7FFFF, 20'sh7FFFF,
                  20'sh7FFFF, PanelBottom, 0});
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // result side: random stalls, one long hold-off to back up the pipeline
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, 4);
         if (results_seen == 300) gap = 200;
         else if ((results_seen / 100) % 4 == 1) gap = 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result('{rsp_status, rsp_distance, rsp_cross_x, rsp_cross_y,
                           rsp_cross_z, rsp_clipped});
         results_seen++;
      end
   end

   initial begin
      req_valid = 1'b0;
      req = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      directed_pairs();
      for (int i = 0; i < 400; i++) send_pair(make_pair($urandom_range(0, 9) < 7));
      wait_drained();
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: set_window(16'd0, 20'sh7FFFF, 20'sh80000);
            1: set_window(16'hFFFF, 20'sd16640, -20'sd640);
            2: set_window(16'($urandom), 20'sd30000, -20'sd3000);
            default: set_window(16'd7300, 20'sh80000, 20'sh7FFFF);
         endcase
         directed_pairs();
         for (int i = 0; i < 220; i++) send_pair(make_pair($urandom_range(0, 9) < 7));
         wait_drained();
      end
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== track_axis_plane_projection.f =====
src/tapp_pkg.sv
src/track_axis_plane_projection.sv
sim/tb_top.sv
